[rtl/tdt_pkg.sv]
package tdt_pkg;

  localparam int unsigned StateW = 6;
  localparam int unsigned ByteW  = 8;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_FEED  = 2'd1;
  localparam logic [1:0] FUNC_END   = 2'd2;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_FEED  = 2'd1,
    KIND_END   = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [ByteW-1:0]  byte_req;
    logic [StateW-1:0] entry_state;
    logic [StateW-1:0] entry_dest_state;
    logic [ByteW-1:0]  entry_out_char;
    logic              entry_final;
  } item_t;

  typedef struct packed {
    logic              fin;
    logic [ByteW-1:0]  out_char;
    logic [StateW-1:0] dest_state;
  } entry_t;

  typedef struct packed {
    logic [StateW-1:0] dest_state;
    logic [ByteW-1:0]  out_char;
    logic              char_valid;
    logic              match_ok;
    logic              is_end;
  } result_t;

  // handshake toward a downstream stage
  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

endpackage

[rtl/tdt_front.sv]
module tdt_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [31:0]   in_data_i,
  input  logic [1:0]    in_func_i,
  output tdt_pkg::hs_t  push_o,
  input  logic          q_ready_i,
  output tdt_pkg::item_t item_o
);
  import tdt_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  keep;
  logic  accept;

  always_comb begin
    item_d                  = item_q;
    keep                    = 1'b1;
    item_d.byte_req         = in_data_i[7:0];
    item_d.entry_state      = in_data_i[13:8];
    item_d.entry_dest_state = in_data_i[19:14];
    item_d.entry_out_char   = in_data_i[27:20];
    item_d.entry_final      = in_data_i[28];
    case (in_func_i)
      FUNC_WRITE: item_d.kind = KIND_WRITE;
      FUNC_FEED:  item_d.kind = KIND_FEED;
      FUNC_END:   item_d.kind = KIND_END;
      default: begin
        // unused code: take the beat, drop the item
        item_d.kind = KIND_WRITE;
        keep        = 1'b0;
      end
    endcase
  end

  assign in_ready_o = !valid_q || q_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (valid_q && q_ready_i) valid_d = 1'b0;
    if (accept) valid_d = keep;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) item_q <= item_d;
  end

  assign push_o.valid = valid_q;
  assign push_o.ready = q_ready_i;
  assign item_o       = item_q;

endmodule

[rtl/tdt_queue.sv]
module tdt_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tdt_pkg::hs_t   push_i,
  input  tdt_pkg::item_t item_i,
  output logic           ready_o,
  output logic           valid_o,
  output tdt_pkg::item_t item_o,
  input  logic           pop_i
);
  import tdt_pkg::*;

  item_t            slots_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]   count_q;
  logic             do_push, do_pop;

  assign ready_o = (count_q != QPtrW'(0) + (QPtrW+1)'(QDepth));
  assign valid_o = (count_q != '0);
  assign item_o  = slots_q[rd_ptr_q];
  assign do_push = push_i.valid && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + (QPtrW+1)'(1);
        2'b01:   count_q <= count_q - (QPtrW+1)'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slots_q[wr_ptr_q] <= item_i;
  end

endmodule

[rtl/tdt_back.sv]
module tdt_back #(
  parameter int StateCount = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  tdt_pkg::item_t  q_item_i,
  output logic            q_pop_o,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output tdt_pkg::result_t res_o
);
  import tdt_pkg::*;

  localparam int unsigned RowW     = (StateCount > 1) ? $clog2(StateCount) : 1;
  localparam int unsigned AddrW    = RowW + ByteW;
  localparam int unsigned MemDepth = StateCount * (2 ** ByteW);

  // reduce a state number into a table row by binary compare-and-subtract
  function automatic logic [RowW-1:0] row_of(input logic [StateW-1:0] st);
    int unsigned v;
    v = 32'(st);
    for (int k = StateW - 1; k >= 0; k--) begin
      if (v >= (32'(StateCount) << k)) v = v - (32'(StateCount) << k);
    end
    return v[RowW-1:0];
  endfunction

  entry_t            mem [MemDepth];
  entry_t            rdata_q;
  logic              s2_valid_q, s2_valid_d;
  logic              s2_end_q, s2_seen_q;
  logic [StateW-1:0] cur_q;
  logic              seen_q;
  logic [StateW-1:0] cur_eff;
  logic              seen_eff;
  logic              s2_move, pop, issue, we;
  logic [AddrW-1:0]  raddr, waddr;
  logic [ByteW-1:0]  rd_col;
  entry_t            wdata;
  result_t           s2_res;

  result_t           ob_q [2];
  logic              ob_wr_q, ob_rd_q;
  logic [1:0]        ob_cnt_q;
  logic              ob_pop;

  assign s2_move = s2_valid_q && (ob_cnt_q != 2'd2);
  assign pop     = q_valid_i && (!s2_valid_q || s2_move);
  assign q_pop_o = pop;
  assign issue   = pop && (q_item_i.kind != KIND_WRITE);
  assign we      = pop && (q_item_i.kind == KIND_WRITE);

  // the state leaving the read stage is the state the next lookup uses
  assign cur_eff  = s2_valid_q ? (s2_end_q ? '0 : rdata_q.dest_state) : cur_q;
  assign seen_eff = s2_valid_q ? !s2_end_q : seen_q;

  assign rd_col = (q_item_i.kind == KIND_END) ? '0 : q_item_i.byte_req;
  assign raddr  = {row_of(cur_eff), rd_col};
  assign waddr  = {row_of(q_item_i.entry_state), q_item_i.byte_req};
  assign wdata  = '{fin:        q_item_i.entry_final,
                    out_char:   q_item_i.entry_out_char,
                    dest_state: q_item_i.entry_dest_state};

  always_ff @(posedge clk_i) begin
    if (we)    mem[waddr] <= wdata;
    if (issue) rdata_q    <= mem[raddr];
  end

  always_comb begin
    s2_valid_d = s2_valid_q;
    if (s2_move) s2_valid_d = 1'b0;
    if (pop)     s2_valid_d = issue;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      cur_q      <= '0;
      seen_q     <= 1'b0;
    end else begin
      s2_valid_q <= s2_valid_d;
      if (s2_move) begin
        cur_q  <= s2_end_q ? '0 : rdata_q.dest_state;
        seen_q <= !s2_end_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s2_end_q  <= (q_item_i.kind == KIND_END);
      s2_seen_q <= seen_eff;
    end
  end

  always_comb begin
    if (s2_end_q) begin
      s2_res = '{dest_state: '0, out_char: '0, char_valid: 1'b0,
                 match_ok: s2_seen_q && rdata_q.fin, is_end: 1'b1};
    end else begin
      s2_res = '{dest_state: rdata_q.dest_state, out_char: rdata_q.out_char,
                 char_valid: (rdata_q.out_char != '0), match_ok: 1'b0,
                 is_end: 1'b0};
    end
  end

  // two-entry output buffer: the read stage never waits on the sink combinationally
  assign res_valid_o = (ob_cnt_q != 2'd0);
  assign res_o       = ob_q[ob_rd_q];
  assign ob_pop      = res_valid_o && res_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ob_wr_q  <= 1'b0;
      ob_rd_q  <= 1'b0;
      ob_cnt_q <= 2'd0;
    end else begin
      if (s2_move) ob_wr_q <= !ob_wr_q;
      if (ob_pop)  ob_rd_q <= !ob_rd_q;
      case ({s2_move, ob_pop})
        2'b10:   ob_cnt_q <= ob_cnt_q + 2'd1;
        2'b01:   ob_cnt_q <= ob_cnt_q - 2'd1;
        default: ob_cnt_q <= ob_cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_move) ob_q[ob_wr_q] <= s2_res;
  end

endmodule

[rtl/table_driven_transducer_core.sv]
// Path: a feed or end beat passes the front register, the queue, the registered
//   memory read and the two-entry output buffer before the master side sees it.
// Throughput: one beat per cycle unless the master side stalls; the limit is the
//   loop from the registered read of the transition memory to the next lookup
//   address (state row, input byte). Writes fill the memory and give no result.
// Reset (rst_ni low, asynchronous) clears state 0, the seen mark and all queues;
//   the transition memory is not cleared and must be written before it is read.
module table_driven_transducer_core #(
  parameter int STATE_COUNT = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // byte_req[7:0], entry_state[13:8], entry_dest_state[19:14],
  // entry_out_char[27:20], entry_final[28], zero[31:29]
  input  logic [31:0] s_axis_tdata,
  // func[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // dest_state[5:0], out_char[13:6], char_valid[14], match_ok[15]
  output logic [15:0] m_axis_tdata,
  // is_end[0]
  output logic        m_axis_tuser
);
  import tdt_pkg::*;

  hs_t     push;
  item_t   front_item, q_item;
  logic    q_ready, q_valid, q_pop;
  result_t res;

  tdt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata),
    .in_func_i  (s_axis_tuser),
    .push_o     (push),
    .q_ready_i  (q_ready),
    .item_o     (front_item)
  );

  tdt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .item_o  (q_item),
    .pop_i   (q_pop)
  );

  tdt_back #(
    .StateCount (STATE_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {res.match_ok, res.char_valid, res.out_char, res.dest_state};
  assign m_axis_tuser = res.is_end;

endmodule

[rtl/tdt_checker.sv]
module tdt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [31:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // end results return to state 0 and carry no output byte
  a_end_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[14:0] == 15'd0)
    else $error("end result carries state or byte");

  // feed results never report success; valid flag follows the byte
  a_feed_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |->
      !m_axis_tdata[15] && (m_axis_tdata[14] == (m_axis_tdata[13:6] != 8'd0)))
    else $error("feed result flags inconsistent");

  // nothing leaves while reset is held
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid)
    else $error("result beat during reset");

endmodule

bind table_driven_transducer_core tdt_checker u_tdt_checker (.*);
